### hdl/rgba_palette_indexer_macros.svh
// Assertion helpers shared by the palette indexer modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef RGBA_PALETTE_INDEXER_MACROS_SVH
`define RGBA_PALETTE_INDEXER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define RPI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

### hdl/rpi_pkg.sv
`default_nettype none

package rpi_pkg;

  localparam int PAL_DEPTH_DEFAULT = 256;
  localparam int CHAN_W            = 8;
  localparam int ENTRY_CNT_W       = 9;
  localparam int COLOR_TYPE_W      = 3;

  localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;

  localparam logic [COLOR_TYPE_W-1:0] CT_GREY  = 3'd0;
  localparam logic [COLOR_TYPE_W-1:0] CT_RGB   = 3'd2;
  localparam logic [COLOR_TYPE_W-1:0] CT_RGBA  = 3'd6;
  localparam logic [COLOR_TYPE_W-1:0] CT_RESET = CT_RGBA;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_READ     = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    op_t               opcode;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
    logic [CHAN_W-1:0] entry_sel;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]      pal_index;
    logic                   is_new;
    logic                   overflow;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic [CHAN_W-1:0]      out_red;
    logic [CHAN_W-1:0]      out_green;
    logic [CHAN_W-1:0]      out_blue;
    logic [CHAN_W-1:0]      out_alpha;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic match;
    logic scan_end;
  } dp_status_t;

  // Expands the channel bytes of one pixel to RGBA by color type.
  function automatic rgba_t expand_pixel(input logic [COLOR_TYPE_W-1:0] ct,
                                         input logic [CHAN_W-1:0] c0,
                                         input logic [CHAN_W-1:0] c1,
                                         input logic [CHAN_W-1:0] c2,
                                         input logic [CHAN_W-1:0] c3);
    rgba_t px;
    unique case (ct)
      CT_GREY: px = '{red: c0, green: c0, blue: c0, alpha: OPAQUE_ALPHA};
      CT_RGB:  px = '{red: c0, green: c1, blue: c2, alpha: OPAQUE_ALPHA};
      CT_RGBA: px = '{red: c0, green: c1, blue: c2, alpha: c3};
      default: px = '{red: c0, green: c0, blue: c0, alpha: c1};
    endcase
    return px;
  endfunction

endpackage

`default_nettype wire

### hdl/rpi_ctrl.sv
`default_nettype none
`include "rgba_palette_indexer_macros.svh"

module rpi_ctrl
  import rpi_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  op_t        opcode,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (opcode == OP_CLASSIFY) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        // A hit ends the search early; otherwise stop once every entry was compared.
        if (status.match || status.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

  `RPI_ASSERT(a_done_in_idle, done |-> state == S_IDLE, "result strobe outside idle")
  `RPI_ASSERT(a_done_after_finish, done |-> $past(state == S_FINISH),
              "result strobe without a finish step")
  `RPI_ASSERT(a_load_only_idle, cmd.load |-> !busy, "item taken while busy")

endmodule

`default_nettype wire

### hdl/rpi_datapath.sv
`default_nettype none
`include "rgba_palette_indexer_macros.svh"

module rpi_datapath
  import rpi_pkg::*;
#(
  parameter int PALETTE_DEPTH = PAL_DEPTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire  [COLOR_TYPE_W-1:0] cfg_data,
  input  item_t                   item,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  output result_t                 result
);

  localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  rgba_t mem [PALETTE_DEPTH];
  rgba_t rd_data;
  logic  [IDX_W-1:0] rd_addr;
  logic  rd_en;
  logic  wr_en;

  logic [COLOR_TYPE_W-1:0] color_type;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    ovf;
  logic                    ovf_next;

  op_t               op_q;
  rgba_t             word_q;
  logic [CHAN_W-1:0] sel_q;
  logic [CNT_W-1:0]  ptr;
  logic              pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx;
  result_t           result_next;

  // Search issues one read per cycle and compares the word read the cycle before.
  assign rd_addr = cmd.load ? item.entry_sel[IDX_W-1:0] : ptr[IDX_W-1:0];
  assign rd_en   = cmd.load || (cmd.scan && (ptr < count));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= word_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign status.match    = pend && (rd_data == word_q);
  assign status.scan_end = (ptr >= count);

  always_comb begin
    result_next = '0;
    count_next  = count;
    ovf_next    = ovf;
    wr_en       = 1'b0;
    unique case (op_q)
      OP_CLASSIFY: begin
        result_next.out_red   = word_q.red;
        result_next.out_green = word_q.green;
        result_next.out_blue  = word_q.blue;
        result_next.out_alpha = word_q.alpha;
        if (hit_q) begin
          result_next.pal_index = CHAN_W'(hit_idx);
        end else if (count < DEPTH_CNT) begin
          wr_en                 = cmd.finish;
          result_next.pal_index = CHAN_W'(count);
          result_next.is_new    = 1'b1;
          count_next            = count + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      OP_READ: begin
        result_next.pal_index = sel_q;
        // Entries at or above the fill count are stale or never written.
        if (ENTRY_CNT_W'(sel_q) < ENTRY_CNT_W'(count)) begin
          result_next.out_red   = rd_data.red;
          result_next.out_green = rd_data.green;
          result_next.out_blue  = rd_data.blue;
          result_next.out_alpha = rd_data.alpha;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
        ovf_next   = 1'b0;
      end
      default: begin
      end
    endcase
    result_next.overflow    = ovf_next;
    result_next.entry_count = ENTRY_CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_type <= CT_RESET;
      count      <= '0;
      ovf        <= 1'b0;
      pend       <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_type <= cfg_data;
      end
      if (cmd.load) begin
        pend  <= 1'b0;
        hit_q <= 1'b0;
      end
      if (cmd.scan) begin
        pend <= (ptr < count);
        if (status.match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd.finish) begin
        count <= count_next;
        ovf   <= ovf_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= item.opcode;
      word_q <= expand_pixel(color_type, item.chan0, item.chan1, item.chan2, item.chan3);
      sel_q  <= item.entry_sel;
      ptr    <= '0;
    end
    if (cmd.scan) begin
      if (ptr < count) begin
        pend_idx <= ptr[IDX_W-1:0];
        ptr      <= ptr + 1'b1;
      end
      if (status.match) begin
        hit_idx <= pend_idx;
      end
    end
    if (cmd.finish) begin
      result <= result_next;
    end
  end

  `RPI_NEVER(a_count_range, count > DEPTH_CNT, "fill count beyond palette depth")
  `RPI_ASSERT(a_ovf_full, ovf |-> count == DEPTH_CNT, "overflow set with free entries")
  `RPI_ASSERT(a_pend_in_use, pend |-> CNT_W'(pend_idx) < count,
              "compared an entry that is not in use")

endmodule

`default_nettype wire

### hdl/rgba_palette_indexer.sv
`default_nettype none
// Exact RGBA palette builder and pixel indexer.
// Items enter on start/item and are taken when start is high and busy is low.
// Opcodes: classify a pixel, read back one palette entry, clear the palette.
// Each item gives one result word on result, marked by a one-cycle done strobe.
// The receiver cannot stall: result is valid only in the cycle done is high.
// Classify expands the pixel by color type and searches the entries in use one
// per cycle through the palette memory's read port; a miss appends the color
// while entries are free and otherwise sets overflow. Read, clear and unused
// opcodes go from the accepting edge straight to the finish step; classify
// first scans until a hit or until every entry in use was compared.
// The scan through the single read port sets how long classify lasts; busy
// stays high until done, and a new item may be taken in the cycle that done
// is high.
// color_type is written on cfg_valid/cfg_data/cfg_ready, taken only while idle.
// Reset empties the palette (fill count zero), clears overflow and sets the
// color type to RGBA; palette memory contents are not cleared and need no pass.

module rgba_palette_indexer
  import rpi_pkg::*;
#(
  parameter int PALETTE_DEPTH = PAL_DEPTH_DEFAULT
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  item_t                   item,
  output logic                    done,
  output result_t                 result,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [COLOR_TYPE_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = !busy;

  rpi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rpi_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule

`default_nettype wire
